// ----- src/assert_macros.svh -----
// Assertion macros shared by the indexed list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset.
`define ILST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ilst assertion failed");
// Implication checked at every rising clock edge outside reset.
`define ILST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilst implication failed");
// Consequence expected in the cycle after the antecedent.
`define ILST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilst next-cycle check failed");
`else
`define ILST_ASSERT(label, clk, rst_n, prop)
`define ILST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ILST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/ilst_pkg.sv -----
// Types and constants of the indexed list engine.
`timescale 1ns / 1ps
package ilst_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned ITEM_BITS_DEF = 32;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned AMT_W  = 8;
  localparam int unsigned LEN_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_ROTATE = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROTATE = 2'd2
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOD  = 3'b010,
    S_ROT  = 3'b100
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   item_value;
    logic [AMT_W-1:0]   rotate_amount;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [VAL_W-1:0]   read_value;
    logic [LEN_W-1:0]   length;
  } rsp_t;

endpackage

// ----- src/ilst_cell.sv -----
// One list cell: holds one word and on insert or rotate takes the new word, a neighbor's or the front word.
`timescale 1ns / 1ps
module ilst_cell #(
  parameter int unsigned ITEM_BITS = ilst_pkg::ITEM_BITS_DEF,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  ilst_pkg::cell_op_e   op_i,
  input  logic [CNT_W-1:0]     pos_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [ITEM_BITS-1:0] new_word_i,
  input  logic [ITEM_BITS-1:0] left_i,
  input  logic [ITEM_BITS-1:0] right_i,
  input  logic [ITEM_BITS-1:0] head_i,
  output logic [ITEM_BITS-1:0] word_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [ITEM_BITS-1:0] word_q;
  logic [ITEM_BITS-1:0] word_d;

  always_comb begin
    word_d = word_q;
    case (op_i)
      ilst_pkg::OP_INSERT: begin
        if (MyIdx == pos_i) begin
          word_d = new_word_i;
        end else if (MyIdx > pos_i) begin
          word_d = left_i;
        end
      end
      ilst_pkg::OP_ROTATE: begin
        // The last occupied cell wraps around to the front word.
        if (MyIdx == count_i - CNT_W'(1)) begin
          word_d = head_i;
        end else begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- src/indexed_list_engine_top.sv -----
// Top level of the indexed list engine: request control and the row of cells.
//
// Channel   Direction  Handshake                       Payload
// request   in         start_i high while busy_o low   req_i (ilst_pkg::req_t)
// result    out        done_o high for one cycle       rsp_o (ilst_pkg::rsp_t)
//
// Append, insert, read and a rotate of an empty list or by zero give their
// result in the cycle after the transaction; busy_o stays low, so requests can
// follow back to back.
// Any other rotate first reduces the amount modulo the length in state S_MOD, one
// amount bit a cycle, then shifts all cells one place per cycle r times in S_ROT, r
// being the reduced amount: busy_o stays high meanwhile, and the result follows.
// Reset empties the list; the cell words themselves are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module indexed_list_engine_top #(
  parameter int unsigned CAPACITY  = ilst_pkg::CAPACITY_DEF,
  parameter int unsigned ITEM_BITS = ilst_pkg::ITEM_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ilst_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output ilst_pkg::rsp_t rsp_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned CMP_W  = CNT_W + ilst_pkg::POS_W;
  localparam int unsigned STEP_W = $clog2(ilst_pkg::AMT_W);

  ilst_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          rem_q, rem_d;
  logic [ilst_pkg::AMT_W-1:0] amt_q, amt_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic                      done_q, done_d;
  ilst_pkg::rsp_t            rsp_q, rsp_d;

  ilst_pkg::cell_op_e        cell_op;
  logic [CNT_W-1:0]          ins_pos;
  logic [ITEM_BITS-1:0]      new_word;
  logic [ITEM_BITS-1:0]      words [CAPACITY];

  logic                      accept;
  logic                      is_append;
  logic                      is_rotate;
  logic [CMP_W-1:0]          pos_cmp;
  logic [CMP_W-1:0]          cnt_cmp;
  logic                      ins_ok;
  logic                      rd_ok;
  logic [ITEM_BITS-1:0]      rd_word;
  logic [CNT_W:0]            rem_sh;
  logic [CNT_W-1:0]          rem_new;

  assign accept    = start_i && (state_q == ilst_pkg::S_IDLE);
  assign is_append = (req_i.kind == ilst_pkg::KIND_APPEND);
  assign is_rotate = (req_i.kind == ilst_pkg::KIND_ROTATE);
  assign pos_cmp   = CMP_W'(req_i.position);
  assign cnt_cmp   = CMP_W'(count_q);
  assign ins_ok    = (count_q < CNT_W'(CAPACITY)) && (is_append || (pos_cmp <= cnt_cmp));
  assign ins_pos   = is_append ? count_q : CNT_W'(req_i.position);
  assign new_word  = ITEM_BITS'(req_i.item_value);
  assign rd_ok     = (pos_cmp < cnt_cmp);
  assign rd_word   = words[IDX_W'(req_i.position)];

  // One step of the restoring remainder: bring in the next amount bit.
  assign rem_sh  = {rem_q, amt_q[ilst_pkg::AMT_W-1]};
  assign rem_new = (rem_sh >= (CNT_W + 1)'(count_q)) ?
                   CNT_W'(rem_sh - (CNT_W + 1)'(count_q)) : CNT_W'(rem_sh);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rem_d   = rem_q;
    amt_d   = amt_q;
    step_d  = step_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    cell_op = ilst_pkg::OP_HOLD;
    case (state_q)
      ilst_pkg::S_IDLE: begin
        if (accept) begin
          rsp_d.ok         = 1'b0;
          rsp_d.read_value = '0;
          rsp_d.length     = ilst_pkg::LEN_W'(count_q);
          case (req_i.kind)
            ilst_pkg::KIND_APPEND, ilst_pkg::KIND_INSERT: begin
              done_d = 1'b1;
              if (ins_ok) begin
                cell_op      = ilst_pkg::OP_INSERT;
                count_d      = count_q + CNT_W'(1);
                rsp_d.ok     = 1'b1;
                rsp_d.length = ilst_pkg::LEN_W'(count_q + CNT_W'(1));
              end
            end
            ilst_pkg::KIND_ROTATE: begin
              rsp_d.ok = 1'b1;
              if ((count_q == '0) || (req_i.rotate_amount == '0)) begin
                done_d = 1'b1;
              end else begin
                state_d = ilst_pkg::S_MOD;
                amt_d   = req_i.rotate_amount;
                rem_d   = '0;
                step_d  = STEP_W'(ilst_pkg::AMT_W - 1);
              end
            end
            ilst_pkg::KIND_READ: begin
              done_d = 1'b1;
              if (rd_ok) begin
                rsp_d.ok         = 1'b1;
                rsp_d.read_value = ilst_pkg::VAL_W'(rd_word);
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ilst_pkg::S_MOD: begin
        rem_d  = rem_new;
        amt_d  = amt_q << 1;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          if (rem_new == '0) begin
            state_d = ilst_pkg::S_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = ilst_pkg::S_ROT;
          end
        end
      end
      ilst_pkg::S_ROT: begin
        cell_op = ilst_pkg::OP_ROTATE;
        rem_d   = rem_q - CNT_W'(1);
        if (rem_q == CNT_W'(1)) begin
          state_d = ilst_pkg::S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ilst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilst_pkg::S_IDLE;
      count_q <= '0;
      rem_q   <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q <= amt_d;
    rsp_q <= rsp_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0] left_w;
    logic [ITEM_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = new_word;
    end else begin : g_inner_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[0];
    end else begin : g_inner_r
      assign right_w = words[i+1];
    end
    ilst_cell #(
      .ITEM_BITS(ITEM_BITS),
      .CNT_W    (CNT_W),
      .IDX      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .pos_i     (ins_pos),
      .count_i   (count_q),
      .new_word_i(new_word),
      .left_i    (left_w),
      .right_i   (right_w),
      .head_i    (words[0]),
      .word_o    (words[i])
    );
  end

  assign busy_o = (state_q != ilst_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ILST_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY))
  `ILST_ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, done_o, !busy_o)
  `ILST_ASSERT_IMPL(a_rot_rem_nonzero, clk_i, rst_ni, state_q == ilst_pkg::S_ROT, rem_q != '0)
  `ILST_ASSERT_NEXT(a_quick_result, clk_i, rst_ni, accept && !is_rotate, done_o)
  `ILST_ASSERT_IMPL(a_rot_count_nonzero, clk_i, rst_ni, state_q != ilst_pkg::S_IDLE, count_q != '0)

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the indexed list engine top level.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned LIST_CAP    = 16;
  localparam int unsigned TOTAL_ITEMS = 1950;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 30;

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           start_i = 1'b0;
  ilst_pkg::req_t req_i   = '0;
  logic           busy_o;
  logic           done_o;
  ilst_pkg::rsp_t rsp_o;

  // Predicted list contents and length.
  logic [31:0] list_words [LIST_CAP];
  int unsigned list_len = 0;

  ilst_pkg::rsp_t pending_rsps [$];
  ilst_pkg::rsp_t oldest_rsp;
  int unsigned    error_count = 0;
  int unsigned    sent_items  = 0;
  int unsigned    burst_left  = 0;

  indexed_list_engine_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit insert_word(int unsigned pos, logic [31:0] word);
    if (list_len >= LIST_CAP || pos > list_len) begin
      return 1'b0;
    end
    for (int unsigned i = list_len; i > pos; i--) begin
      list_words[i] = list_words[i-1];
    end
    list_words[pos] = word;
    list_len++;
    return 1'b1;
  endfunction

  function automatic ilst_pkg::rsp_t predict_response(ilst_pkg::req_t r);
    ilst_pkg::rsp_t rsp;
    logic [31:0]    rotated [LIST_CAP];
    int unsigned    shift;
    rsp = '0;
    case (r.kind)
      ilst_pkg::KIND_APPEND: begin
        rsp.ok = insert_word(list_len, r.item_value);
      end
      ilst_pkg::KIND_INSERT: begin
        rsp.ok = insert_word(r.position, r.item_value);
      end
      ilst_pkg::KIND_ROTATE: begin
        rsp.ok = 1'b1;
        if (list_len != 0) begin
          shift = r.rotate_amount % list_len;
          for (int unsigned i = 0; i < list_len; i++) begin
            rotated[i] = list_words[(i + shift) % list_len];
          end
          for (int unsigned i = 0; i < list_len; i++) begin
            list_words[i] = rotated[i];
          end
        end
      end
      default: begin
        if (r.position < list_len) begin
          rsp.ok         = 1'b1;
          rsp.read_value = list_words[r.position];
        end
      end
    endcase
    rsp.length = ilst_pkg::LEN_W'(list_len);
    return rsp;
  endfunction

  function automatic ilst_pkg::req_t make_req(ilst_pkg::kind_e k, logic [3:0] p,
                                              logic [31:0] v, logic [7:0] a);
    ilst_pkg::req_t r;
    r.kind          = k;
    r.position      = p;
    r.item_value    = v;
    r.rotate_amount = a;
    return r;
  endfunction

  // While growing, the list gains words rarely, so partly filled lists see
  // many rotates, reads and rejected inserts before the list fills up.
  function automatic ilst_pkg::req_t random_request(bit growing);
    ilst_pkg::req_t r;
    int unsigned    pick;
    r.position      = 4'($urandom_range(0, 15));
    r.item_value    = $urandom;
    r.rotate_amount = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (growing) begin
      if (pick < 6) r.kind = ilst_pkg::KIND_APPEND;
      else if (pick < 12) r.kind = ilst_pkg::KIND_INSERT;
      else if (pick < 56) r.kind = ilst_pkg::KIND_ROTATE;
      else r.kind = ilst_pkg::KIND_READ;
    end else begin
      r.kind = ilst_pkg::kind_e'(pick % 4);
    end
    if (r.kind == ilst_pkg::KIND_INSERT && $urandom_range(0, 1) == 1) begin
      r.position = 4'($urandom_range(0, (list_len < 15) ? list_len : 15));
    end
    if (r.kind == ilst_pkg::KIND_ROTATE && list_len != 0 && $urandom_range(0, 3) == 0) begin
      r.rotate_amount = 8'(list_len * $urandom_range(0, 255 / list_len));
    end
    return r;
  endfunction

  // Holds start high until the engine takes the transaction, then records
  // the predicted result. Start is only lowered when a gap follows.
  task automatic send_request(ilst_pkg::req_t r);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_rsps.push_back(predict_response(r));
    sent_items++;
  endtask

  task automatic test_empty_list();
    send_request(make_req(ilst_pkg::KIND_READ, 4'd15, 32'h1234_5678, 8'd0));
    send_request(make_req(ilst_pkg::KIND_ROTATE, 4'd0, 32'h0, 8'd255));
    send_request(make_req(ilst_pkg::KIND_INSERT, 4'd1, 32'hFFFF_FFFF, 8'd0));
    send_request(make_req(ilst_pkg::KIND_INSERT, 4'd15, 32'h0, 8'd0));
  endtask

  task automatic test_short_list();
    send_request(make_req(ilst_pkg::KIND_INSERT, 4'd0, 32'h0000_0000, 8'd0));
    send_request(make_req(ilst_pkg::KIND_APPEND, 4'd15, 32'hFFFF_FFFF, 8'd255));
    send_request(make_req(ilst_pkg::KIND_INSERT, 4'd2, 32'h5A5A_5A5A, 8'd0));
    send_request(make_req(ilst_pkg::KIND_INSERT, 4'd1, 32'h8000_0001, 8'd0));
    send_request(make_req(ilst_pkg::KIND_ROTATE, 4'd0, 32'h0, 8'd0));
    send_request(make_req(ilst_pkg::KIND_ROTATE, 4'd0, 32'h0, 8'd4));
    send_request(make_req(ilst_pkg::KIND_ROTATE, 4'd0, 32'h0, 8'd255));
    for (int unsigned p = 0; p <= 4; p++) begin
      send_request(make_req(ilst_pkg::KIND_READ, 4'(p), 32'h0, 8'd0));
    end
  endtask

  task automatic test_random_growth();
    while (list_len < LIST_CAP && sent_items < 1200) begin
      send_request(random_request(1'b1));
    end
  endtask

  task automatic test_full_list();
    while (list_len < LIST_CAP) begin
      send_request(make_req(ilst_pkg::KIND_APPEND, 4'd0, $urandom, 8'd0));
    end
    send_request(make_req(ilst_pkg::KIND_APPEND, 4'd0, 32'hDEAD_BEEF, 8'd0));
    send_request(make_req(ilst_pkg::KIND_INSERT, 4'd0, 32'hFFFF_FFFF, 8'd0));
    send_request(make_req(ilst_pkg::KIND_INSERT, 4'd15, 32'h0, 8'd0));
    send_request(make_req(ilst_pkg::KIND_ROTATE, 4'd0, 32'h0, 8'd16));
    send_request(make_req(ilst_pkg::KIND_ROTATE, 4'd0, 32'h0, 8'd1));
    send_request(make_req(ilst_pkg::KIND_ROTATE, 4'd0, 32'h0, 8'd255));
    send_request(make_req(ilst_pkg::KIND_READ, 4'd0, 32'h0, 8'd0));
    send_request(make_req(ilst_pkg::KIND_READ, 4'd15, 32'h0, 8'd0));
  endtask

  task automatic test_random_full();
    while (sent_items < TOTAL_ITEMS) begin
      send_request(random_request(1'b0));
    end
  endtask

  // Every result must match the oldest prediction field by field.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsps.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("Unexpected result: ok=%0b read_value=%h length=%0d",
                   rsp_o.ok, rsp_o.read_value, rsp_o.length);
        end
      end else begin
        oldest_rsp = pending_rsps.pop_front();
        if (rsp_o.ok !== oldest_rsp.ok || rsp_o.read_value !== oldest_rsp.read_value ||
            rsp_o.length !== oldest_rsp.length) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Mismatch: expected ok=%0b read_value=%h length=%0d,",
                     oldest_rsp.ok, oldest_rsp.read_value, oldest_rsp.length,
                     " got ok=%0b read_value=%h length=%0d",
                     rsp_o.ok, rsp_o.read_value, rsp_o.length);
          end
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_short_list();
    test_random_growth();
    test_full_list();
    test_random_full();
    start_i <= 1'b0;
    waited = 0;
    while (pending_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_rsps.size() != 0) begin
      error_count++;
      $display("%0d results never arrived", pending_rsps.size());
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
